[hdl/stepper_half_step_sequencer_core_assert.svh]
// Assertion macros used by the checker file shss_checker.sv.
`ifndef STEPPER_HALF_STEP_SEQUENCER_CORE_ASSERT_SVH
`define STEPPER_HALF_STEP_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SHSS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("shss assertion failed");

// Next-cycle implication, disabled while in reset.
`define SHSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("shss assertion failed");

`endif

[hdl/shss_pkg.sv]
package shss_pkg;

  localparam int unsigned CFG_W   = 10;
  localparam int unsigned COIL_W  = 4;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned STEPS_W = 31;
  localparam int unsigned PHASE_W = 3;

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_MOVE    = 2'd1;
  localparam logic [1:0] OP_SET_DIR = 2'd2;

  localparam logic [PHASE_W-1:0] PHASE_LAST = 3'd7;
  localparam logic [STEPS_W-1:0] STEPS_MAX  = 31'h7FFF_FFFF;
  localparam logic [POS_W-1:0]   MOST_NEG   = 32'h8000_0000;

  // Half-step coil sequence, bit0 drives IN1.
  localparam logic [COIL_W-1:0] HALF_PATTERNS [8] = '{
    4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
  };

  typedef struct packed {
    logic [1:0]        opcode;
    logic signed [31:0] signed_steps;
    logic              dir_bit;
  } shss_in_t;

  typedef struct packed {
    logic [COIL_W-1:0]  coils;
    logic signed [31:0] position;
    logic               running;
    logic [STEPS_W-1:0] steps_left;
  } shss_out_t;

endpackage

[hdl/stepper_half_step_sequencer_core.sv]
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+-------------------------
// in       | input     | in_valid_i / in_ready_o | in_data_i (shss_in_t)
// out      | output    | out_valid_o/out_ready_i | out_data_o (shss_out_t)
// cfg      | input     | cfg_we_i                | cfg_wdata_i (hold ticks)
//
// One item per cycle while the output is not stalled.
// Each item passes through the input register and then the result register around the step engine.
// Reset clears all step state, sets the hold to one tick and empties both registers.
// A stalled output holds its result while one more item waits in the input register.
module stepper_half_step_sequencer_core import shss_pkg::*; #(
  parameter int unsigned HOLD_BITS = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  shss_in_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output shss_out_t        out_data_o,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  logic      item_valid;
  shss_in_t  item;
  shss_out_t res;
  logic      fire;

  // Advance when the result register is free or being drained.
  assign fire = item_valid && (!out_valid_o || out_ready_i);

  shss_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .pop_i        (fire),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  shss_step_engine #(
    .HOLD_BITS (HOLD_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (item),
    .res_o       (res)
  );

  shss_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[hdl/shss_in_stage.sv]
module shss_in_stage import shss_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  shss_in_t in_data_i,
  input  logic     pop_i,
  output logic     item_valid_o,
  output shss_in_t item_o
);

  logic     valid_q, valid_d;
  shss_in_t data_q;

  assign in_ready_o = !valid_q || pop_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = data_q;

endmodule

[hdl/shss_step_engine.sv]
module shss_step_engine import shss_pkg::*; #(
  parameter int unsigned HOLD_BITS = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             fire_i,
  input  shss_in_t         item_i,
  output shss_out_t        res_o
);

  localparam logic [HOLD_BITS-1:0] HoldOne = HOLD_BITS'(1);

  logic [HOLD_BITS-1:0] hold_q;
  logic [HOLD_BITS-1:0] hcnt_q, hcnt_d;
  logic [STEPS_W-1:0]   rem_q, rem_d;
  logic                 dir_q, dir_d;
  logic [PHASE_W-1:0]   phase_q, phase_d;
  logic                 active_q, active_d;
  logic [POS_W-1:0]     pos_q, pos_d;

  logic [HOLD_BITS-1:0] limit;
  logic [HOLD_BITS-1:0] hc;
  logic [HOLD_BITS-1:0] hc_next;
  logic [PHASE_W-1:0]   pi;
  logic [PHASE_W-1:0]   idx;
  logic [POS_W-1:0]     raw;
  logic [POS_W-1:0]     mag;
  logic [COIL_W-1:0]    coils;

  // A zero hold acts as one tick.
  assign limit = (hold_q == '0) ? HoldOne : hold_q;

  always_comb begin
    hcnt_d   = hcnt_q;
    rem_d    = rem_q;
    dir_d    = dir_q;
    phase_d  = phase_q;
    active_d = active_q;
    pos_d    = pos_q;
    coils    = '0;
    pi       = active_q ? phase_q : '0;
    hc       = active_q ? hcnt_q : '0;
    idx      = dir_q ? ~pi : pi;
    hc_next  = hc + HoldOne;
    raw      = item_i.signed_steps;
    mag      = -raw;
    case (item_i.opcode)
      OP_TICK: begin
        if (active_q || rem_q != '0) begin
          coils = HALF_PATTERNS[idx];
          if (hc_next >= limit || hc_next == '0) begin
            hcnt_d = '0;
            if (pi == PHASE_LAST) begin
              // Step done: advance position, count down remaining steps.
              pos_d    = dir_q ? pos_q - 32'd1 : pos_q + 32'd1;
              if (rem_q != '0) begin
                rem_d = rem_q - 31'd1;
              end
              active_d = 1'b0;
              phase_d  = '0;
            end else begin
              phase_d  = pi + 3'd1;
              active_d = 1'b1;
            end
          end else begin
            hcnt_d   = hc_next;
            phase_d  = pi;
            active_d = 1'b1;
          end
        end
      end
      OP_MOVE: begin
        active_d = 1'b0;
        phase_d  = '0;
        hcnt_d   = '0;
        if (raw[POS_W-1]) begin
          rem_d = (raw == MOST_NEG) ? STEPS_MAX : mag[STEPS_W-1:0];
          dir_d = 1'b1;
        end else begin
          rem_d = raw[STEPS_W-1:0];
          dir_d = 1'b0;
        end
      end
      OP_SET_DIR: begin
        active_d = 1'b0;
        phase_d  = '0;
        hcnt_d   = '0;
        dir_d    = item_i.dir_bit;
      end
      default: begin
        // Unused opcode: report status only.
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q   <= HoldOne;
      hcnt_q   <= '0;
      rem_q    <= '0;
      dir_q    <= 1'b0;
      phase_q  <= '0;
      active_q <= 1'b0;
      pos_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        hold_q <= HOLD_BITS'(cfg_wdata_i);
      end
      if (fire_i) begin
        hcnt_q   <= hcnt_d;
        rem_q    <= rem_d;
        dir_q    <= dir_d;
        phase_q  <= phase_d;
        active_q <= active_d;
        pos_q    <= pos_d;
      end
    end
  end

  always_comb begin
    res_o.coils      = coils;
    res_o.position   = pos_d;
    res_o.running    = (rem_d != '0) || active_d;
    res_o.steps_left = rem_d;
  end

endmodule

[hdl/shss_out_stage.sv]
module shss_out_stage import shss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  shss_out_t res_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output shss_out_t out_data_o
);

  logic      valid_q, valid_d;
  shss_out_t data_q;

  always_comb begin
    valid_d = valid_q;
    if (fire_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[hdl/shss_checker.sv]
`include "stepper_half_step_sequencer_core_assert.svh"

module shss_checker import shss_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input shss_out_t out_data_o
);

  `SHSS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  `SHSS_ASSERT_IMPL(a_coil_pattern, out_valid_o, $countones(out_data_o.coils) <= 2)

  `SHSS_ASSERT_IMPL(a_steps_running, out_valid_o && out_data_o.steps_left != '0, out_data_o.running)

  `SHSS_ASSERT_IMPL(a_result_has_cause, $rose(out_valid_o), $past(in_valid_i && in_ready_o, 2))

endmodule

bind stepper_half_step_sequencer_core shss_checker u_shss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

[tb/sv/stepper_half_step_sequencer_core_checker.sv]
`timescale 1ns / 100ps

module stepper_half_step_sequencer_core_checker import shss_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  shss_in_t         in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  shss_out_t        out_data_i,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);

  localparam logic [COIL_W-1:0] COIL_SEQ [8] = '{
    4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
  };

  logic [CFG_W-1:0]   hold_ticks;
  logic [STEPS_W-1:0] steps_owed;
  logic               ccw;
  logic [PHASE_W-1:0] phase;
  logic [CFG_W-1:0]   hold_cnt;
  logic               stepping;
  logic [POS_W-1:0]   pos;
  shss_out_t          status_q [$];
  int unsigned        errors = 0;

  assign fail_count_o = errors;

  task automatic abandon_step();
    stepping = 1'b0;
    phase    = '0;
    hold_cnt = '0;
  endtask

  task automatic predict_status(input shss_in_t item, output shss_out_t res);
    logic [COIL_W-1:0] coil;
    logic [CFG_W-1:0]  lim;
    logic [31:0]       mag;
    coil = '0;
    lim  = hold_ticks;
    if (lim == '0) lim = CFG_W'(1);
    case (item.opcode)
      OP_TICK: begin
        if (!stepping && steps_owed != '0) begin
          stepping = 1'b1;
          phase    = '0;
          hold_cnt = '0;
        end
        if (stepping) begin
          coil     = COIL_SEQ[ccw ? ~phase : phase];
          hold_cnt = hold_cnt + 1'b1;
          if (hold_cnt >= lim || hold_cnt == '0) begin
            hold_cnt = '0;
            if (phase == PHASE_LAST) begin
              pos = ccw ? pos - 32'd1 : pos + 32'd1;
              if (steps_owed != '0) steps_owed = steps_owed - 1'b1;
              stepping = 1'b0;
              phase    = '0;
            end else begin
              phase = phase + 1'b1;
            end
          end
        end
      end
      OP_MOVE: begin
        abandon_step();
        if (item.signed_steps[31]) begin
          mag = ~item.signed_steps + 32'd1;
          // clamp the most negative count
          if (mag > {1'b0, STEPS_MAX}) mag = {1'b0, STEPS_MAX};
          steps_owed = mag[STEPS_W-1:0];
          ccw        = 1'b1;
        end else begin
          steps_owed = item.signed_steps[STEPS_W-1:0];
          ccw        = 1'b0;
        end
      end
      OP_SET_DIR: begin
        abandon_step();
        ccw = item.dir_bit;
      end
      default: ;
    endcase
    res.coils      = coil;
    res.position   = pos;
    res.running    = (steps_owed != '0) || stepping;
    res.steps_left = steps_owed;
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] seen);
    if (want !== seen) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    shss_out_t want;
    if (!rst_ni) begin
      hold_ticks = CFG_W'(1);
      steps_owed = '0;
      ccw        = 1'b0;
      pos        = '0;
      abandon_step();
      status_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) hold_ticks = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        if (status_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data_i);
        end else begin
          want = status_q.pop_front();
          check_field("coils", want.coils, out_data_i.coils);
          check_field("position", want.position, out_data_i.position);
          check_field("running", want.running, out_data_i.running);
          check_field("steps_left", want.steps_left, out_data_i.steps_left);
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_status(in_data_i, want);
        status_q.push_back(want);
      end
      pending_o <= status_q.size();
    end
  end

endmodule

[tb/sv/stepper_half_step_sequencer_core_test.sv]
`timescale 1ns / 100ps

module stepper_half_step_sequencer_core_test;
  import shss_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int unsigned STALL_LIMIT = 2000;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  shss_in_t         in_data_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  shss_out_t        out_data_o;
  logic             cfg_we_i    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles = 0;
  int unsigned sent_count  = 0;
  bit          tx_quiet    = 1'b0;
  bit          rx_quiet    = 1'b0;

  always #5 clk_i = ~clk_i;

  stepper_half_step_sequencer_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  stepper_half_step_sequencer_core_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic shss_in_t make_item(input logic [1:0] op, input logic [31:0] steps,
                                         input logic dir);
    shss_in_t it;
    it.opcode       = op;
    it.signed_steps = steps;
    it.dir_bit      = dir;
    return it;
  endfunction

  function automatic shss_in_t random_item();
    shss_in_t    it;
    int unsigned pick;
    it   = make_item(OP_TICK, $urandom, 1'($urandom_range(1)));
    pick = $urandom_range(99);
    if (pick < 12) it.opcode = OP_MOVE;
    else if (pick < 24) it.opcode = OP_SET_DIR;
    else if (pick < 32) it.opcode = OP_UNUSED;
    return it;
  endfunction

  task automatic send_item(input shss_in_t item);
    int unsigned gap;
    if (sent_count % 40 == 0) tx_quiet = ($urandom_range(3) == 0);
    gap = tx_quiet ? 0 : $urandom_range(9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    sent_count++;
  endtask

  // Drop valid and wait until every expected status has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_hold(input logic [CFG_W-1:0] ticks);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ticks;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin : drain_results
    int unsigned stall;
    int unsigned served;
    served = 0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (served % 32 == 0) rx_quiet = ($urandom_range(3) == 0);
      stall = rx_quiet ? 0 : $urandom_range(9);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      served++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : run
    logic [CFG_W-1:0] holds [6];
    logic [CFG_W-1:0] eff;
    int unsigned      budget;
    int unsigned      used;
    int unsigned      ticks;
    int               n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero hold behaves as one tick
    load_hold('0);
    send_item(make_item(OP_TICK, 32'h0, 1'b0));
    send_item(make_item(OP_MOVE, 32'd1, 1'b1));
    repeat (9) send_item(make_item(OP_TICK, 32'hFFFF_FFFF, 1'b1));
    send_item(make_item(OP_SET_DIR, 32'h0, 1'b1));
    send_item(make_item(OP_MOVE, 32'hFFFF_FFFF, 1'b0));
    repeat (3) send_item(make_item(OP_TICK, 32'h0, 1'b0));
    // abandon the step partway through
    send_item(make_item(OP_SET_DIR, 32'hFFFF_FFFF, 1'b0));
    send_item(make_item(OP_TICK, 32'h0, 1'b0));
    send_item(make_item(OP_MOVE, 32'h0, 1'b1));
    send_item(make_item(OP_MOVE, 32'h8000_0000, 1'b0));
    send_item(make_item(OP_TICK, 32'h0, 1'b0));
    send_item(make_item(OP_MOVE, 32'h7FFF_FFFF, 1'b0));
    send_item(make_item(OP_TICK, 32'h0, 1'b0));
    send_item(make_item(OP_MOVE, 32'h8000_0001, 1'b0));
    send_item(make_item(OP_UNUSED, 32'hFFFF_FFFF, 1'b1));

    holds    = '{10'd1023, 10'd1, 10'd2, 10'd0, 10'd4, 10'd3};
    holds[4] = CFG_W'($urandom_range(3, 5));
    foreach (holds[p]) begin
      load_hold(holds[p]);
      budget = (holds[p] == 10'd1023) ? 60 : 195;
      eff    = (holds[p] == '0) ? 10'd1 : holds[p];
      used   = 0;
      while (used < budget) begin
        if ($urandom_range(9) < 7) begin
          // short move, then ticks to finish it unless the budget runs out
          n = $urandom_range(1, 3);
          send_item(make_item(OP_MOVE, $urandom_range(1) ? -n : n, 1'($urandom_range(1))));
          used++;
          ticks = n * 8 * eff + $urandom_range(3);
          for (int k = 0; k < ticks && used < budget; k++) begin
            send_item(make_item(OP_TICK, $urandom, 1'($urandom_range(1))));
            used++;
          end
        end else begin
          repeat ($urandom_range(1, 8)) begin
            send_item(random_item());
            used++;
          end
        end
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
